// ===== hdl/pdcm_pkg.sv =====
package pdcm_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int TS_W   = 16;
    localparam int DUTY_W = 15;
    localparam int OUT_W  = 16;
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // 100 percent in units of 1/256 percent.
    localparam logic [DUTY_W-1:0] FULL_Q8 = 15'd25600;

    localparam logic [15:0] MISMATCH_RST = 16'd50;
    localparam logic [3:0]  WHOLE_RST    = 4'd4;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] REG_INVERT   = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_WHOLE    = 2'd2;

    // Capture phases; codes at or above PH_IDLE mean no run is active.
    localparam logic [2:0] PH_RISE0     = 3'd0;
    localparam logic [2:0] PH_RISE1     = 3'd1;
    localparam logic [2:0] PH_SKIP_FALL = 3'd2;
    localparam logic [2:0] PH_FALL0     = 3'd3;
    localparam logic [2:0] PH_FALL1     = 3'd4;
    localparam logic [2:0] PH_IDLE      = 3'd5;

    localparam logic [1:0] SLOT_RISE0 = 2'd0;
    localparam logic [1:0] SLOT_RISE1 = 2'd1;
    localparam logic [1:0] SLOT_FALL0 = 2'd2;
    localparam logic [1:0] SLOT_FALL1 = 2'd3;

    typedef enum logic [1:0] {
        STATUS_MEASURED = 2'd0,
        STATUS_FLAT     = 2'd1,
        STATUS_NOISE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_CALC,
        CS_WHOLE,
        CS_MUL,
        CS_DIV,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       accept;
        logic       stamp_we;
        logic [1:0] stamp_sel;
        logic       stamp_clr;
        logic       calc;
        logic       whole_step;
        logic       mul;
        logic       div_step;
        logic       emit_now;
        logic       emit_late;
        logic       emit_meas;
        status_t    emit_status;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic all_equal;
        logic period_zero;
        logic mismatch;
        logic whole_ge_max;
        logic rem_ge_period;
        logic div_last;
    } sts_t;

endpackage

// ===== hdl/pdcm_ctrl.sv =====
module pdcm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       mode,
    input  logic             rising,
    input  pdcm_pkg::sts_t   sts,
    output pdcm_pkg::cmd_t   cmd
);

    pdcm_pkg::ctrl_state_t state_reg;
    pdcm_pkg::ctrl_state_t state_next;
    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;

    logic fire;
    logic run_active;
    logic is_start;
    logic is_tick;
    logic is_edge;
    logic want_rise;
    logic take;
    logic stops;

    assign in_ready   = (state_reg == pdcm_pkg::CS_IDLE) && sts.out_free;
    assign fire       = in_valid && in_ready;
    assign run_active = phase_reg < pdcm_pkg::PH_IDLE;
    assign is_start   = fire && (mode == pdcm_pkg::MODE_START);
    assign is_tick    = fire && (mode == pdcm_pkg::MODE_TICK) && run_active;
    assign is_edge    = fire && (mode == pdcm_pkg::MODE_EDGE) && run_active;
    assign want_rise  = (phase_reg == pdcm_pkg::PH_RISE0) || (phase_reg == pdcm_pkg::PH_RISE1);
    // An edge of the wrong polarity for the current phase is dropped.
    assign take       = is_edge && (rising == want_rise);
    assign stops      = sts.all_equal || sts.period_zero || sts.mismatch || sts.whole_ge_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdcm_pkg::CS_IDLE;
            phase_reg <= pdcm_pkg::PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            pdcm_pkg::CS_IDLE:
            begin
                if (is_start)
                begin
                    phase_next = pdcm_pkg::PH_RISE0;
                end
                else if (is_tick)
                begin
                    phase_next = pdcm_pkg::PH_IDLE;
                end
                else if (take)
                begin
                    case (phase_reg)
                        pdcm_pkg::PH_RISE0:     phase_next = pdcm_pkg::PH_RISE1;
                        pdcm_pkg::PH_RISE1:     phase_next = pdcm_pkg::PH_SKIP_FALL;
                        pdcm_pkg::PH_SKIP_FALL: phase_next = pdcm_pkg::PH_FALL0;
                        pdcm_pkg::PH_FALL0:     phase_next = pdcm_pkg::PH_FALL1;
                        pdcm_pkg::PH_FALL1:
                        begin
                            phase_next = pdcm_pkg::PH_IDLE;
                            state_next = pdcm_pkg::CS_CALC;
                        end
                        default:                phase_next = phase_reg;
                    endcase
                end
            end
            pdcm_pkg::CS_CALC:
            begin
                state_next = pdcm_pkg::CS_WHOLE;
            end
            pdcm_pkg::CS_WHOLE:
            begin
                if (stops)
                begin
                    state_next = pdcm_pkg::CS_IDLE;
                end
                else if (!sts.rem_ge_period)
                begin
                    state_next = pdcm_pkg::CS_MUL;
                end
            end
            pdcm_pkg::CS_MUL:
            begin
                state_next = pdcm_pkg::CS_DIV;
            end
            pdcm_pkg::CS_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = pdcm_pkg::CS_DONE;
                end
            end
            pdcm_pkg::CS_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = pdcm_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = pdcm_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = pdcm_pkg::STATUS_FLAT;
        cmd.accept      = fire;
        case (state_reg)
            pdcm_pkg::CS_IDLE:
            begin
                cmd.stamp_clr = is_tick;
                cmd.emit_now  = is_tick;
                case (phase_reg)
                    pdcm_pkg::PH_RISE0:
                    begin
                        cmd.stamp_we  = take;
                        cmd.stamp_sel = pdcm_pkg::SLOT_RISE0;
                    end
                    pdcm_pkg::PH_RISE1:
                    begin
                        cmd.stamp_we  = take;
                        cmd.stamp_sel = pdcm_pkg::SLOT_RISE1;
                    end
                    pdcm_pkg::PH_FALL0:
                    begin
                        cmd.stamp_we  = take;
                        cmd.stamp_sel = pdcm_pkg::SLOT_FALL0;
                    end
                    pdcm_pkg::PH_FALL1:
                    begin
                        cmd.stamp_we  = take;
                        cmd.stamp_sel = pdcm_pkg::SLOT_FALL1;
                    end
                    default:
                    begin
                        cmd.stamp_we = 1'b0;
                    end
                endcase
            end
            pdcm_pkg::CS_CALC:
            begin
                cmd.calc = 1'b1;
            end
            pdcm_pkg::CS_WHOLE:
            begin
                cmd.emit_late   = stops;
                cmd.whole_step  = !stops && sts.rem_ge_period;
                cmd.emit_status = sts.all_equal ? pdcm_pkg::STATUS_FLAT
                                                : pdcm_pkg::STATUS_NOISE;
            end
            pdcm_pkg::CS_MUL:
            begin
                cmd.mul = 1'b1;
            end
            pdcm_pkg::CS_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            pdcm_pkg::CS_DONE:
            begin
                cmd.emit_meas   = sts.out_free;
                cmd.emit_status = pdcm_pkg::STATUS_MEASURED;
            end
            default:
            begin
                cmd.accept = fire;
            end
        endcase
    end

endmodule

// ===== hdl/pdcm_dp.sv =====
module pdcm_dp
#(
    parameter int TIMER_BITS = pdcm_pkg::TIMER_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pdcm_pkg::cmd_t                  cmd,
    output pdcm_pkg::sts_t                  sts,
    input  logic [pdcm_pkg::TS_W-1:0]       timestamp,
    input  logic                            pin_level,
    input  logic                            invert_duty,
    input  logic [15:0]                     max_period_mismatch,
    input  logic [3:0]                      max_whole_periods,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pdcm_pkg::status_t               out_status,
    output logic [pdcm_pkg::DUTY_W-1:0]     out_duty,
    output logic [pdcm_pkg::OUT_W-1:0]      out_period,
    output logic [pdcm_pkg::OUT_W-1:0]      out_high
);

    localparam int DW = pdcm_pkg::DUTY_W;
    localparam int PW = TIMER_BITS + DW;
    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] stamp_reg [4];
    logic [TIMER_BITS-1:0] period_reg;
    logic [TIMER_BITS-1:0] period1_reg;
    logic [TIMER_BITS-1:0] rem_reg;
    logic                  eq_reg;
    logic                  pin_reg;
    logic [3:0]            cnt_reg;
    logic [TIMER_BITS-1:0] div_rem_reg;
    logic [DW-1:0]         qr_reg;

    logic                      out_valid_reg;
    pdcm_pkg::status_t         out_status_reg;
    logic [DW-1:0]             out_duty_reg;
    logic [pdcm_pkg::OUT_W-1:0] out_period_reg;
    logic [pdcm_pkg::OUT_W-1:0] out_high_reg;

    logic [TIMER_BITS-1:0] ts_w;
    logic [TIMER_BITS-1:0] diff;
    logic [TIMER_BITS-1:0] share;
    logic [PW-1:0]         product;
    logic [TIMER_BITS:0]   trial;
    logic                  trial_ge;
    logic [TIMER_BITS:0]   trial_sub;
    logic                  pin_now_high;
    logic                  pin_late_high;

    assign ts_w = TIMER_BITS'(timestamp);
    assign diff = (period_reg >= period1_reg) ? period_reg - period1_reg
                                              : period1_reg - period_reg;
    assign share   = invert_duty ? period_reg - rem_reg : rem_reg;
    assign product = PW'(share) * PW'(pdcm_pkg::FULL_Q8);

    // One quotient bit per step; the remainder stays below the period.
    assign trial     = {div_rem_reg, qr_reg[DW-1]};
    assign trial_ge  = trial >= {1'b0, period_reg};
    assign trial_sub = trial - {1'b0, period_reg};

    assign pin_now_high  = pin_level ^ invert_duty;
    assign pin_late_high = pin_reg ^ invert_duty;

    assign sts.out_free      = !out_valid_reg || out_ready;
    assign sts.all_equal     = eq_reg;
    assign sts.period_zero   = period_reg == '0;
    assign sts.mismatch      = CW'(diff) >= CW'(max_period_mismatch);
    assign sts.whole_ge_max  = cnt_reg >= max_whole_periods;
    assign sts.rem_ge_period = rem_reg >= period_reg;
    assign sts.div_last      = cnt_reg == 4'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pin_reg <= pin_level;
        end
        if (cmd.stamp_clr)
        begin
            for (int i = 0; i < 4; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (cmd.stamp_we)
        begin
            stamp_reg[cmd.stamp_sel] <= ts_w;
        end

        if (cmd.calc)
        begin
            period_reg  <= stamp_reg[3] - stamp_reg[2];
            period1_reg <= stamp_reg[1] - stamp_reg[0];
            rem_reg     <= stamp_reg[3] - stamp_reg[1];
            eq_reg      <= (stamp_reg[0] == stamp_reg[1]) && (stamp_reg[1] == stamp_reg[2])
                           && (stamp_reg[2] == stamp_reg[3]);
            cnt_reg     <= 4'd0;
        end
        else if (cmd.whole_step)
        begin
            rem_reg <= rem_reg - period_reg;
            cnt_reg <= cnt_reg + 4'd1;
        end
        else if (cmd.mul)
        begin
            div_rem_reg <= product[PW-1:DW];
            qr_reg      <= product[DW-1:0];
            cnt_reg     <= 4'(DW - 1);
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= trial_ge ? trial_sub[TIMER_BITS-1:0] : trial[TIMER_BITS-1:0];
            qr_reg      <= {qr_reg[DW-2:0], trial_ge};
            cnt_reg     <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_now || cmd.emit_late || cmd.emit_meas)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_now || cmd.emit_late)
        begin
            out_status_reg <= cmd.emit_status;
            out_period_reg <= '0;
            out_high_reg   <= '0;
            if (cmd.emit_now ? pin_now_high : pin_late_high)
            begin
                out_duty_reg <= pdcm_pkg::FULL_Q8;
            end
            else
            begin
                out_duty_reg <= '0;
            end
        end
        else if (cmd.emit_meas)
        begin
            out_status_reg <= cmd.emit_status;
            out_duty_reg   <= qr_reg;
            out_period_reg <= pdcm_pkg::OUT_W'(period_reg);
            out_high_reg   <= pdcm_pkg::OUT_W'(rem_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_duty   = out_duty_reg;
    assign out_period = out_period_reg;
    assign out_high   = out_high_reg;

endmodule

// ===== hdl/pwm_duty_capture_meter_top.sv =====
// PWM duty meter. Each input beat is a start, a captured edge with its timer stamp, or a
// timer overflow tick. After a start the block records a pair of rising edges, skips a falling
// edge and records a pair of falling edges; the last of these ends the run and produces one
// result beat with status, period, high time and duty in 1/256 percent. An overflow tick
// during a run ends it at once as a flatline, with duty taken from the pin level. Beats that
// produce no result, and the overflow tick, are handled without leaving the idle state. The
// run-ending edge starts a repeated-subtraction loop with one step per whole period between
// capture points, then a multiply and a 15-step restoring divider that produces the duty
// bits. Rejected runs finish sooner. A new input beat is taken only when the controller is
// idle and the output register is empty or being drained. TIMER_BITS sets the width of the
// internal timestamp arithmetic; the user must write registers over the APB port only while
// the block is idle, which the block itself does not enforce.
module pwm_duty_capture_meter_top
#(
    parameter int TIMER_BITS = pdcm_pkg::TIMER_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdcm_pkg::CFG_AW-1:0] paddr,
    input  logic [pdcm_pkg::CFG_DW-1:0] pwdata,
    output logic [pdcm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // timestamp[15:0], rising[16], pin_level[17]
    input  logic [1:0]                  s_tuser,   // mode[1:0]

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // duty_q8[14:0], period_ticks[30:15],
                                                   // high_ticks[46:31]
    output logic [1:0]                  m_tuser    // status[1:0]
);

    logic        invert_reg;
    logic [15:0] mismatch_reg;
    logic [3:0]  whole_reg;
    logic        cfg_we;

    pdcm_pkg::cmd_t    cmd;
    pdcm_pkg::sts_t    sts;
    pdcm_pkg::status_t out_status;
    logic [pdcm_pkg::DUTY_W-1:0] out_duty;
    logic [pdcm_pkg::OUT_W-1:0]  out_period;
    logic [pdcm_pkg::OUT_W-1:0]  out_high;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg   <= 1'b0;
            mismatch_reg <= pdcm_pkg::MISMATCH_RST;
            whole_reg    <= pdcm_pkg::WHOLE_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                pdcm_pkg::REG_INVERT:   invert_reg   <= pwdata[0];
                pdcm_pkg::REG_MISMATCH: mismatch_reg <= pwdata[15:0];
                pdcm_pkg::REG_WHOLE:    whole_reg    <= pwdata[3:0];
                default:                invert_reg   <= invert_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pdcm_pkg::REG_INVERT:   prdata = {31'd0, invert_reg};
            pdcm_pkg::REG_MISMATCH: prdata = {16'd0, mismatch_reg};
            pdcm_pkg::REG_WHOLE:    prdata = {28'd0, whole_reg};
            default:                prdata = '0;
        endcase
    end

    pdcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (s_tuser),
        .rising   (s_tdata[16]),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdcm_dp
    #(
        .TIMER_BITS (TIMER_BITS)
    )
    u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .timestamp           (s_tdata[15:0]),
        .pin_level           (s_tdata[17]),
        .invert_duty         (invert_reg),
        .max_period_mismatch (mismatch_reg),
        .max_whole_periods   (whole_reg),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_status          (out_status),
        .out_duty            (out_duty),
        .out_period          (out_period),
        .out_high            (out_high)
    );

    assign m_tuser = out_status;
    assign m_tdata = {1'b0, out_high, out_period, out_duty};

    // A result is only ever loaded into an output register that is empty or being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_now || cmd.emit_late || cmd.emit_meas) |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending output beat");

    // A measured duty never exceeds 100 percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == pdcm_pkg::STATUS_MEASURED))
            |-> (m_tdata[14:0] <= pdcm_pkg::FULL_Q8))
        else $error("measured duty above full scale");

    // Flatline and rejected results carry no period and no high time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != pdcm_pkg::STATUS_MEASURED)) |-> (m_tdata[46:15] == '0))
        else $error("unmeasured result with nonzero timing fields");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_BEATS = 67;
    localparam int NUM_SETTINGS = 6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] stamp;
        logic        rise;
        logic        pin;
    } capture_t;

    typedef struct packed {
        pdcm_pkg::status_t status;
        logic [14:0]       duty;
        logic [15:0]       period;
        logic [15:0]       high;
    } duty_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pdcm_pkg::CFG_AW-1:0] paddr = '0;
    logic [pdcm_pkg::CFG_DW-1:0] pwdata = '0;
    logic [pdcm_pkg::CFG_DW-1:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // timestamp[15:0], rising[16], pin_level[17]
    logic [1:0]  s_tuser = '0;     // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // duty_q8[14:0], period_ticks[30:15], high_ticks[46:31]
    logic [1:0]  m_tuser;          // status[1:0]

    pwm_duty_capture_meter_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    capture_t     beat_q[$];
    duty_result_t result_q[$];

    // Predicted state of the meter and its register copies.
    logic [2:0]  m_phase = pdcm_pkg::PH_IDLE;
    logic [15:0] m_stamp [4] = '{default: '0};
    logic        m_invert = 1'b0;
    logic [15:0] m_mismatch = pdcm_pkg::MISMATCH_RST;
    logic [3:0]  m_whole_max = pdcm_pkg::WHOLE_RST;

    int beats_pushed = 0;
    int beats_taken = 0;
    int stim_count = 0;
    int errors = 0;
    int results_checked = 0;
    int n_measured = 0;
    int n_flat = 0;
    int n_noise = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic duty_result_t pin_duty(input pdcm_pkg::status_t st, input logic pin);
        duty_result_t r;
        r.status = st;
        r.duty = (pin ^ m_invert) ? pdcm_pkg::FULL_Q8 : '0;
        r.period = '0;
        r.high = '0;
        return r;
    endfunction

    task automatic meter_predict(input capture_t c);
        duty_result_t r;
        logic [15:0]  period;
        logic [15:0]  period1;
        logic [15:0]  span;
        logic [15:0]  width;
        int unsigned  whole;
        int unsigned  diff;
        logic [31:0]  share;
        bit           emit;
        emit = 1'b0;
        r = pin_duty(pdcm_pkg::STATUS_FLAT, c.pin);
        case (c.mode)
            pdcm_pkg::MODE_START: m_phase = pdcm_pkg::PH_RISE0;
            pdcm_pkg::MODE_TICK:
                if (m_phase < pdcm_pkg::PH_IDLE)
                begin
                    m_stamp = '{default: '0};
                    m_phase = pdcm_pkg::PH_IDLE;
                    emit = 1'b1;
                end
            pdcm_pkg::MODE_EDGE:
                case (m_phase)
                    pdcm_pkg::PH_RISE0:
                        if (c.rise)
                        begin
                            m_stamp[0] = c.stamp;
                            m_phase = pdcm_pkg::PH_RISE1;
                        end
                    pdcm_pkg::PH_RISE1:
                        if (c.rise)
                        begin
                            m_stamp[1] = c.stamp;
                            m_phase = pdcm_pkg::PH_SKIP_FALL;
                        end
                    pdcm_pkg::PH_SKIP_FALL:
                        if (!c.rise)
                            m_phase = pdcm_pkg::PH_FALL0;
                    pdcm_pkg::PH_FALL0:
                        if (!c.rise)
                        begin
                            m_stamp[2] = c.stamp;
                            m_phase = pdcm_pkg::PH_FALL1;
                        end
                    pdcm_pkg::PH_FALL1:
                        if (!c.rise)
                        begin
                            m_stamp[3] = c.stamp;
                            m_phase = pdcm_pkg::PH_IDLE;
                            emit = 1'b1;
                            period = m_stamp[3] - m_stamp[2];
                            period1 = m_stamp[1] - m_stamp[0];
                            span = m_stamp[3] - m_stamp[1];
                            if (m_stamp[0] == m_stamp[1] && m_stamp[1] == m_stamp[2]
                                && m_stamp[2] == m_stamp[3])
                                r = pin_duty(pdcm_pkg::STATUS_FLAT, c.pin);
                            else if (period == '0)
                                r = pin_duty(pdcm_pkg::STATUS_NOISE, c.pin);
                            else
                            begin
                                width = span % period;
                                whole = span / period;
                                diff = (period >= period1) ? period - period1 : period1 - period;
                                if (diff >= m_mismatch || whole >= m_whole_max)
                                    r = pin_duty(pdcm_pkg::STATUS_NOISE, c.pin);
                                else
                                begin
                                    share = m_invert ? 32'(period - width) : 32'(width);
                                    r.status = pdcm_pkg::STATUS_MEASURED;
                                    r.duty = 15'((share * 32'(pdcm_pkg::FULL_Q8))
                                                 / 32'(period));
                                    r.period = period;
                                    r.high = width;
                                end
                            end
                        end
                    default: ;
                endcase
            default: ;
        endcase
        if (emit)
        begin
            result_q.push_back(r);
            case (r.status)
                pdcm_pkg::STATUS_MEASURED: n_measured++;
                pdcm_pkg::STATUS_FLAT: n_flat++;
                default: n_noise++;
            endcase
        end
    endtask

    // Input side: one beat in flight, refilled from beat_q.
    always @(posedge clk or negedge rst_n)
    begin
        capture_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                meter_predict({s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[17]});
                beats_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (beat_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, nxt.pin, nxt.rise, nxt.stamp};
                    s_tuser <= nxt.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random backpressure (none while steady) and comparison against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        duty_result_t got;
        duty_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = pdcm_pkg::status_t'(m_tuser);
                got.duty = m_tdata[14:0];
                got.period = m_tdata[30:15];
                got.high = m_tdata[46:31];
                results_checked++;
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result status %0d duty %0d period %0d high %0d",
                                 $time, got.status, got.duty, got.period, got.high);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.duty !== want.duty
                        || got.period !== want.period || got.high !== want.high)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: expected status %0d duty %0d period %0d ",
                                      "high %0d, got status %0d duty %0d period %0d high %0d"},
                                     $time, want.status, want.duty, want.period, want.high,
                                     got.status, got.duty, got.period, got.high);
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL pwm_duty_capture_meter_top");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic [1:0] mode, input logic [15:0] ts, input logic r,
                             input logic pin);
        capture_t c;
        c.mode = mode;
        c.stamp = ts;
        c.rise = r;
        c.pin = pin;
        beat_q.push_back(c);
        beats_pushed++;
        if (mode != MODE_UNUSED)
            stim_count++;
    endtask

    // A start followed by the edges of a run up to the cut. After each beat an ignored beat
    // may follow: an edge of the wrong polarity for the next step, or the unused mode.
    task automatic push_run(input logic [15:0] t0, input int p1, input int per, input int w,
                            input int k, input logic pin, input int cut, input bit noisy);
        capture_t run [6];
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        t1 = t0 + 16'(p1);
        t3 = t1 + 16'(k * per + w);
        t2 = t3 - 16'(per);
        run[0] = {pdcm_pkg::MODE_START, 16'($urandom), 1'($urandom), 1'($urandom)};
        run[1] = {pdcm_pkg::MODE_EDGE, t0, 1'b1, 1'($urandom)};
        run[2] = {pdcm_pkg::MODE_EDGE, t1, 1'b1, 1'($urandom)};
        run[3] = {pdcm_pkg::MODE_EDGE, 16'($urandom), 1'b0, 1'($urandom)};
        run[4] = {pdcm_pkg::MODE_EDGE, t2, 1'b0, 1'($urandom)};
        run[5] = {pdcm_pkg::MODE_EDGE, t3, 1'b0, pin};
        for (int i = 0; i <= cut && i < 6; i++)
        begin
            push_beat(run[i].mode, run[i].stamp, run[i].rise, run[i].pin);
            if (noisy && $urandom_range(99) < 20)
            begin
                if ($urandom_range(1))
                    push_beat(MODE_UNUSED, 16'($urandom), 1'($urandom), 1'($urandom));
                else
                    push_beat(pdcm_pkg::MODE_EDGE, 16'($urandom), (i >= 2) ? 1'b1 : 1'b0,
                              1'($urandom));
            end
        end
    endtask

    task automatic push_random_run(input int cut, input bit noisy);
        int per;
        int p1;
        int w;
        int k;
        int d;
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            per = 0;
        else if (roll < 15)
            per = $urandom_range(1, 4);
        else if (roll < 85)
            per = $urandom_range(5, 2000);
        else
            per = $urandom_range(2001, 65535);
        roll = $urandom_range(99);
        if (roll < 15)
            p1 = per;
        else if (roll < 30)
            p1 = $urandom_range(0, 65535);
        else
        begin
            d = $urandom_range(0, int'(m_mismatch) + 2);
            p1 = $urandom_range(1) ? per + d : per - d;
        end
        w = (per > 0) ? $urandom_range(0, per - 1) : $urandom_range(0, 300);
        k = $urandom_range(0, int'(m_whole_max));
        if (k * per + w > 65535)
            k = 0;
        push_run(16'($urandom), p1, per, w, k, 1'($urandom), cut, noisy);
    endtask

    task automatic drain();
        while (beats_taken != beats_pushed || result_q.size() != 0)
            @(posedge clk);
        // A beat without a result may still be in progress after the last one came back.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pdcm_pkg::REG_INVERT: m_invert = val[0];
            pdcm_pkg::REG_MISMATCH: m_mismatch = val[15:0];
            pdcm_pkg::REG_WHOLE: m_whole_max = val[3:0];
            default: ;
        endcase
    endtask

    initial
    begin
        int unsigned set_inv [NUM_SETTINGS];
        int unsigned set_mis [NUM_SETTINGS];
        int unsigned set_whole [NUM_SETTINGS];
        int phase_start;
        int roll;
        set_inv = '{1, 0, 1, 0, 1, 0};
        set_mis = '{50, 65535, 0, 1, 300, 20};
        set_whole = '{4, 15, 1, 1, 15, 2};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset settings.
        push_beat(pdcm_pkg::MODE_EDGE, 16'hFFFF, 1'b1, 1'b1);     // ignored while idle
        push_beat(pdcm_pkg::MODE_TICK, 16'h0000, 1'b0, 1'b1);     // ignored while idle
        push_beat(MODE_UNUSED, 16'hFFFF, 1'b1, 1'b1);
        push_beat(pdcm_pkg::MODE_START, 16'h0000, 1'b0, 1'b0);
        push_beat(pdcm_pkg::MODE_TICK, 16'h0000, 1'b0, 1'b1);     // flatline with the pin high
        push_beat(pdcm_pkg::MODE_START, 16'h0000, 1'b0, 1'b0);
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0100, 1'b1, 1'b0);     // abandoned by the restart
        push_beat(pdcm_pkg::MODE_START, 16'hFFFF, 1'b1, 1'b1);
        push_beat(pdcm_pkg::MODE_EDGE, 16'hFFF0, 1'b1, 1'b1);
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0000, 1'b0, 1'b1);     // wrong polarity
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0054, 1'b1, 1'b1);     // timer wrapped, period 100
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0060, 1'b1, 1'b0);     // wrong polarity
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0070, 1'b0, 1'b0);     // skipped falling edge
        push_beat(pdcm_pkg::MODE_EDGE, 16'h00C0, 1'b0, 1'b0);
        push_beat(pdcm_pkg::MODE_EDGE, 16'h0124, 1'b0, 1'b1);     // two periods plus 8 ticks
        push_run(16'h8000, 0, 0, 0, 0, 1'b0, 5, 1'b0);  // all four stamps equal
        push_run(16'h0000, 5, 0, 7, 0, 1'b1, 5, 1'b0);  // zero period
        drain();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            reg_write(pdcm_pkg::REG_INVERT, set_inv[s]);
            reg_write(pdcm_pkg::REG_MISMATCH, set_mis[s]);
            reg_write(pdcm_pkg::REG_WHOLE, set_whole[s]);
            steady = (s == 4);
            phase_start = stim_count;
            while (stim_count - phase_start < PHASE_BEATS)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    push_random_run(5, $urandom_range(99) < 30);
                else if (roll < 85)
                begin
                    push_random_run($urandom_range(0, 4), 1'b0);
                    push_beat(pdcm_pkg::MODE_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
                end
                else if (roll < 92)
                    push_random_run($urandom_range(0, 4), 1'b1);
                else
                    repeat ($urandom_range(1, 6))
                        push_beat(2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
            end
            drain();
        end
        steady = 1'b0;

        errors += result_q.size();
        $display("Sent %0d input beats across %0d register settings, with idle and stall gaps.",
                 beats_pushed, NUM_SETTINGS + 1);
        $display("Checked %0d results: %0d measured, %0d flatline, %0d rejected; %0d errors.",
                 results_checked, n_measured, n_flat, n_noise, errors);
        if (errors == 0)
            $display("PASS pwm_duty_capture_meter_top");
        else
            $display("FAIL pwm_duty_capture_meter_top");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pdcm_pkg.sv
hdl/pdcm_ctrl.sv
hdl/pdcm_dp.sv
hdl/pwm_duty_capture_meter_top.sv
test/tb_top.sv
